>>> rtl/core/prqs_pkg.sv
package prqs_pkg;

  localparam int ENTRY_W = 5;
  localparam logic [15:0] SLICE_RESET = 16'd100;
  localparam logic [2:0] ADDR_TIME_SLICE = 3'd0;

  typedef enum logic [1:0] {
    REQ_READY = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_BLOCK = 2'd2
  } req_code_t;

  localparam logic [1:0] LVL_IDLE = 2'd0;
  localparam logic [1:0] LVL_USER = 2'd1;
  localparam logic [1:0] LVL_SYS  = 2'd2;
  localparam logic [1:0] LVL_IRQ  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT_NEW,
    S_PUT_CUR,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] thread_id;
    logic [1:0] thread_priority;
    logic       thread_round_robin;
  } req_t;

  typedef struct packed {
    logic       switched;
    logic [3:0] prev_thread;
    logic [3:0] running_thread;
    logic [1:0] running_priority;
    logic       dropped;
  } rsp_t;

endpackage

>>> rtl/core/prqs_store.sv
module prqs_store #(
  parameter int ADDR_W  = 6,
  parameter int ENTRIES = 48
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            addr,
  input  logic [prqs_pkg::ENTRY_W-1:0] wdata,
  output logic [prqs_pkg::ENTRY_W-1:0] rdata
);

  logic [prqs_pkg::ENTRY_W-1:0] mem [0:ENTRIES-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/prqs_cfg.sv
module prqs_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [15:0] time_slice_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice_ticks <= prqs_pkg::SLICE_RESET;
    end else if (psel && penable && pwrite && paddr == prqs_pkg::ADDR_TIME_SLICE) begin
      time_slice_ticks <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == prqs_pkg::ADDR_TIME_SLICE) ? {16'd0, time_slice_ticks} : 32'd0;

endmodule

>>> rtl/core/prqs_core.sv
module prqs_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  prqs_pkg::req_t               req,
  input  logic [15:0]                  time_slice_ticks,
  output logic                         busy,
  output logic                         done,
  output prqs_pkg::rsp_t               rsp,
  output logic                         mem_we,
  output logic                         mem_re,
  output logic [PW+1:0]                mem_addr,
  output logic [prqs_pkg::ENTRY_W-1:0] mem_wdata,
  input  logic [prqs_pkg::ENTRY_W-1:0] mem_rdata
);

  localparam logic [CW-1:0] FULL    = CW'(QUEUE_DEPTH);
  localparam logic [PW:0]   DEPTH_X = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST    = PW'(QUEUE_DEPTH - 1);

  prqs_pkg::state_t state, state_next;
  prqs_pkg::req_t   item, item_next;
  prqs_pkg::rsp_t   rsp_next;

  logic [PW-1:0] heads      [0:2];
  logic [PW-1:0] heads_next [0:2];
  logic [CW-1:0] counts      [0:2];
  logic [CW-1:0] counts_next [0:2];

  logic [3:0]  cur_id, cur_id_next;
  logic [1:0]  cur_lvl, cur_lvl_next;
  logic        cur_rr, cur_rr_next;
  logic [15:0] slice_left, slice_left_next;
  logic [3:0]  prev, prev_next;
  logic        dropped, dropped_next;
  logic        enq_cur, enq_cur_next;
  logic        disp, disp_next;
  logic [1:0]  sel, sel_next;
  logic        done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= prqs_pkg::S_IDLE;
      done       <= 1'b0;
      cur_id     <= '0;
      cur_lvl    <= prqs_pkg::LVL_IDLE;
      cur_rr     <= 1'b0;
      slice_left <= '0;
      for (int i = 0; i < 3; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      state      <= state_next;
      done       <= done_next;
      cur_id     <= cur_id_next;
      cur_lvl    <= cur_lvl_next;
      cur_rr     <= cur_rr_next;
      slice_left <= slice_left_next;
      heads      <= heads_next;
      counts     <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    rsp     <= rsp_next;
    prev    <= prev_next;
    dropped <= dropped_next;
    enq_cur <= enq_cur_next;
    disp    <= disp_next;
    sel     <= sel_next;
  end

  always_comb begin
    logic       put_en;
    logic [1:0] put_q;
    logic [4:0] put_data;
    logic [PW:0] pos;
    logic       fin;
    logic       sw;
    logic       is_ready;
    logic       preempt;
    logic       expire;

    state_next      = state;
    item_next       = item;
    rsp_next        = rsp;
    prev_next       = prev;
    dropped_next    = dropped;
    enq_cur_next    = enq_cur;
    disp_next       = disp;
    sel_next        = sel;
    heads_next      = heads;
    counts_next     = counts;
    cur_id_next     = cur_id;
    cur_lvl_next    = cur_lvl;
    cur_rr_next     = cur_rr;
    slice_left_next = slice_left;
    done_next       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = '0;
    mem_wdata       = '0;
    put_en          = 1'b0;
    put_q           = '0;
    put_data        = '0;
    pos             = '0;
    fin             = 1'b0;
    sw              = 1'b0;
    is_ready        = 1'b0;
    preempt         = 1'b0;
    expire          = 1'b0;

    case (state)
      prqs_pkg::S_IDLE: begin
        if (start) begin
          item_next    = req;
          prev_next    = cur_id;
          dropped_next = 1'b0;
          is_ready = req.req_type == prqs_pkg::REQ_READY &&
                     req.thread_priority != prqs_pkg::LVL_IDLE;
          preempt  = is_ready &&
                     ((req.thread_priority == prqs_pkg::LVL_IRQ &&
                       cur_lvl != prqs_pkg::LVL_IRQ) ||
                      (req.thread_priority != prqs_pkg::LVL_IRQ &&
                       cur_lvl == prqs_pkg::LVL_IDLE));
          expire   = req.req_type == prqs_pkg::REQ_TICK && cur_rr &&
                     slice_left[15:1] == 15'd0;
          enq_cur_next = (preempt || expire) && cur_lvl != prqs_pkg::LVL_IDLE;
          disp_next    = preempt || expire || req.req_type == prqs_pkg::REQ_BLOCK;
          if (req.req_type == prqs_pkg::REQ_TICK && cur_rr && !expire) begin
            slice_left_next = slice_left - 16'd1;
          end
          if (expire) begin
            slice_left_next = '0;
          end
          if (is_ready) begin
            state_next = prqs_pkg::S_PUT_NEW;
          end else if (enq_cur_next) begin
            state_next = prqs_pkg::S_PUT_CUR;
          end else if (disp_next) begin
            state_next = prqs_pkg::S_READ;
          end else begin
            fin = 1'b1;
          end
        end
      end
      prqs_pkg::S_PUT_NEW: begin
        put_en   = 1'b1;
        put_q    = item.thread_priority - 2'd1;
        put_data = {item.thread_round_robin, item.thread_id};
        if (enq_cur) begin
          state_next = prqs_pkg::S_PUT_CUR;
        end else if (disp) begin
          state_next = prqs_pkg::S_READ;
        end else begin
          fin = 1'b1;
        end
      end
      prqs_pkg::S_PUT_CUR: begin
        put_en     = 1'b1;
        put_q      = cur_lvl - 2'd1;
        put_data   = {cur_rr, cur_id};
        state_next = prqs_pkg::S_READ;
      end
      prqs_pkg::S_READ: begin
        // Pick the highest non-empty level and issue the head read.
        if (counts[2] != '0) begin
          sel_next = prqs_pkg::LVL_IRQ;
        end else if (counts[1] != '0) begin
          sel_next = prqs_pkg::LVL_SYS;
        end else if (counts[0] != '0) begin
          sel_next = prqs_pkg::LVL_USER;
        end else begin
          sel_next = prqs_pkg::LVL_IDLE;
        end
        if (sel_next == prqs_pkg::LVL_IDLE) begin
          cur_id_next     = '0;
          cur_lvl_next    = prqs_pkg::LVL_IDLE;
          cur_rr_next     = 1'b0;
          slice_left_next = time_slice_ticks;
          sw  = 1'b1;
          fin = 1'b1;
        end else begin
          put_q    = sel_next - 2'd1;
          mem_re   = 1'b1;
          mem_addr = {put_q, heads[put_q]};
          heads_next[put_q]  = (heads[put_q] == LAST) ? '0 : heads[put_q] + PW'(1);
          counts_next[put_q] = counts[put_q] - CW'(1);
          state_next = prqs_pkg::S_LOAD;
        end
      end
      prqs_pkg::S_LOAD: begin
        cur_id_next     = mem_rdata[3:0];
        cur_rr_next     = mem_rdata[4];
        cur_lvl_next    = sel;
        slice_left_next = time_slice_ticks;
        sw  = 1'b1;
        fin = 1'b1;
      end
      default: begin
        state_next = prqs_pkg::S_IDLE;
      end
    endcase

    // Append at the tail, or drop and flag when the queue is full.
    if (put_en) begin
      if (counts[put_q] == FULL) begin
        dropped_next = 1'b1;
      end else begin
        pos = {1'b0, heads[put_q]} + (PW + 1)'(counts[put_q]);
        if (pos >= DEPTH_X) begin
          pos = pos - DEPTH_X;
        end
        mem_we    = 1'b1;
        mem_addr  = {put_q, pos[PW-1:0]};
        mem_wdata = put_data;
        counts_next[put_q] = counts[put_q] + CW'(1);
      end
    end

    if (fin) begin
      state_next                = prqs_pkg::S_IDLE;
      done_next                 = 1'b1;
      rsp_next.switched         = sw;
      rsp_next.prev_thread      = prev_next;
      rsp_next.running_thread   = cur_id_next;
      rsp_next.running_priority = cur_lvl_next;
      rsp_next.dropped          = dropped_next;
    end
  end

  assign busy = state != prqs_pkg::S_IDLE;

  a_port_excl: assert property (@(posedge clk) disable iff (rst) mem_we |-> !mem_re)
    else $error("store written and read in one cycle");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    state == prqs_pkg::S_LOAD |-> $past(state) == prqs_pkg::S_READ)
    else $error("load without a head read");

  a_idle_cur: assert property (@(posedge clk) disable iff (rst)
    cur_lvl == prqs_pkg::LVL_IDLE |-> cur_id == 4'd0 && !cur_rr)
    else $error("idle level with a non-idle thread");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    counts[0] <= FULL && counts[1] <= FULL && counts[2] <= FULL)
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/priority_ready_queue_scheduler.sv
// Channel   Direction  Handshake                  Payload
// request   in         start && !busy             req  (prqs_pkg::req_t)
// result    out        done, one cycle, no stall  rsp  (prqs_pkg::rsp_t)
// config    in         psel & penable & pwrite    pwdata, paddr (APB, pready tied high)
//
// From acceptance to its result strobe, an item steps in order through the queue store
// accesses it needs (new-thread append, preempted-thread append, head read) and, after a
// head read of a non-empty level, a load of the read data; the single-port store serializes them.
// A tick that only counts down, or an ignored request, reports on the next cycle.
// Synchronous active-high reset empties all queues and makes idle thread 0 current.
// The result cannot be stalled; busy holds off new transactions while one is in flight.
module priority_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // request transaction
  input  logic                start,
  input  prqs_pkg::req_t      req,
  output logic                busy,
  // result transaction
  output logic                done,
  output prqs_pkg::rsp_t      rsp,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PW      = $clog2(QUEUE_DEPTH);
  localparam int ENTRIES = 3 * (1 << PW);

  logic [15:0]                  time_slice_ticks;
  logic                         mem_we;
  logic                         mem_re;
  logic [PW+1:0]                mem_addr;
  logic [prqs_pkg::ENTRY_W-1:0] mem_wdata;
  logic [prqs_pkg::ENTRY_W-1:0] mem_rdata;

  assign pready = 1'b1;

  // Hold the slice length register.
  prqs_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .time_slice_ticks (time_slice_ticks)
  );

  // Sequence appends, head reads and dispatch over the store.
  prqs_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .req              (req),
    .time_slice_ticks (time_slice_ticks),
    .busy             (busy),
    .done             (done),
    .rsp              (rsp),
    .mem_we           (mem_we),
    .mem_re           (mem_re),
    .mem_addr         (mem_addr),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata)
  );

  // Keep all three level queues in one store, addressed {level - 1, slot}.
  prqs_store #(
    .ADDR_W  (PW + 2),
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
